@@ src/lodtsig_pkg.sv @@
// Shared types and constants for the LOD triangle strip index generator.
// Used by every module of the block; depends on nothing.

package lodtsig_pkg;

  // Grid geometry and detail levels.
  localparam int GRID_SIZE   = 1201;
  localparam int LEVEL_COUNT = 8;

  // Field widths.
  localparam int IDX_W    = 21;
  localparam int LEVEL_W  = 3;
  localparam int STEP_W   = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W  = 24;
  localparam int IN_TDATA_W = 8;

  // Derived counter widths.
  localparam int COL_W    = $clog2(GRID_SIZE);
  localparam int ROW_W    = $clog2(GRID_SIZE);
  localparam int STRIDE_W = LEVEL_W + STEP_W;
  localparam int SUM_W    = ((COL_W > STRIDE_W) ? COL_W : STRIDE_W) + 1;
  localparam int LAST_COL = GRID_SIZE - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL = 1'b0,
    CFG_STEP  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_TOP    = 2'd1,
    PH_BOTTOM = 2'd2,
    PH_END    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             degenerate;
    logic             strip_end;
  } res_t;

endpackage

@@ src/lodtsig_cfg.sv @@
// Configuration registers (level and column step) and the column stride they select.
// Depends on lodtsig_pkg.

module lodtsig_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lodtsig_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lodtsig_pkg::CFG_W-1:0]       cfg_wdata_i,
  output logic [lodtsig_pkg::STRIDE_W-1:0]    stride_o
);

  logic [lodtsig_pkg::LEVEL_W-1:0]  level_q;
  logic [lodtsig_pkg::STEP_W-1:0]   step_q;
  logic [lodtsig_pkg::LEVEL_W-1:0]  level_eff;
  logic [lodtsig_pkg::STRIDE_W-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      step_q  <= lodtsig_pkg::STEP_W'(1);
    end else if (cfg_we_i) begin
      unique case (lodtsig_pkg::cfg_reg_e'(cfg_idx_i))
        lodtsig_pkg::CFG_LEVEL: level_q <= cfg_wdata_i[lodtsig_pkg::LEVEL_W-1:0];
        lodtsig_pkg::CFG_STEP:  step_q  <= cfg_wdata_i[lodtsig_pkg::STEP_W-1:0];
      endcase
    end
  end

  // Levels past the table top saturate at the coarsest level.
  always_comb begin
    if (int'(level_q) >= lodtsig_pkg::LEVEL_COUNT) begin
      level_eff = lodtsig_pkg::LEVEL_W'(lodtsig_pkg::LEVEL_COUNT - 1);
    end else begin
      level_eff = level_q;
    end
    prod = lodtsig_pkg::STRIDE_W'(level_eff) * lodtsig_pkg::STRIDE_W'(step_q);
    // Level zero walks every column; a zero product also falls back to one.
    if (level_eff == '0 || prod == '0) begin
      stride_o = lodtsig_pkg::STRIDE_W'(1);
    end else begin
      stride_o = prod;
    end
  end

endmodule

@@ src/lodtsig_seq.sv @@
// Strip sequencer: row, column and phase counters and the index they produce.
// Depends on lodtsig_pkg.

module lodtsig_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic                              restart_i,
  input  logic [lodtsig_pkg::STRIDE_W-1:0]  stride_i,
  output lodtsig_pkg::res_t                 res_o
);

  lodtsig_pkg::phase_e             phase_q, phase_d, cur_phase;
  logic [lodtsig_pkg::ROW_W-1:0]   row_q, row_d, cur_row;
  logic [lodtsig_pkg::IDX_W-1:0]   base_q, base_d, cur_base;
  logic [lodtsig_pkg::COL_W-1:0]   col_q, col_d, cur_col, col_adv;
  logic [lodtsig_pkg::SUM_W-1:0]   col_sum;
  logic                            col_last;
  logic                            row_last;

  // A restart request behaves as if the state were back at the strip start.
  always_comb begin
    if (restart_i) begin
      cur_phase = lodtsig_pkg::PH_START;
      cur_row   = '0;
      cur_base  = '0;
      cur_col   = '0;
    end else begin
      cur_phase = phase_q;
      cur_row   = row_q;
      cur_base  = base_q;
      cur_col   = col_q;
    end
    col_sum  = lodtsig_pkg::SUM_W'(cur_col) + lodtsig_pkg::SUM_W'(stride_i);
    col_adv  = (col_sum > lodtsig_pkg::SUM_W'(lodtsig_pkg::LAST_COL)) ?
               lodtsig_pkg::COL_W'(lodtsig_pkg::LAST_COL) : col_sum[lodtsig_pkg::COL_W-1:0];
    col_last = (cur_col >= lodtsig_pkg::COL_W'(lodtsig_pkg::LAST_COL));
    row_last = (cur_row >= lodtsig_pkg::ROW_W'(lodtsig_pkg::GRID_SIZE - 2));
  end

  // Next state.
  always_comb begin
    phase_d = cur_phase;
    row_d   = cur_row;
    base_d  = cur_base;
    col_d   = cur_col;
    unique case (cur_phase)
      lodtsig_pkg::PH_START: begin
        col_d   = '0;
        phase_d = lodtsig_pkg::PH_TOP;
      end
      lodtsig_pkg::PH_TOP: begin
        phase_d = lodtsig_pkg::PH_BOTTOM;
      end
      lodtsig_pkg::PH_BOTTOM: begin
        if (col_last) begin
          phase_d = lodtsig_pkg::PH_END;
        end else begin
          col_d   = col_adv;
          phase_d = lodtsig_pkg::PH_TOP;
        end
      end
      lodtsig_pkg::PH_END: begin
        col_d   = '0;
        phase_d = lodtsig_pkg::PH_START;
        if (row_last) begin
          row_d  = '0;
          base_d = '0;
        end else begin
          row_d  = cur_row + lodtsig_pkg::ROW_W'(1);
          base_d = cur_base + lodtsig_pkg::IDX_W'(lodtsig_pkg::GRID_SIZE);
        end
      end
    endcase
  end

  // Result for the current request.
  always_comb begin
    res_o = '0;
    unique case (cur_phase)
      lodtsig_pkg::PH_START: begin
        res_o.vertex_index = cur_base;
        res_o.degenerate   = 1'b1;
      end
      lodtsig_pkg::PH_TOP: begin
        res_o.vertex_index = cur_base + lodtsig_pkg::IDX_W'(cur_col);
      end
      lodtsig_pkg::PH_BOTTOM: begin
        res_o.vertex_index = cur_base + lodtsig_pkg::IDX_W'(lodtsig_pkg::GRID_SIZE)
                           + lodtsig_pkg::IDX_W'(cur_col);
      end
      lodtsig_pkg::PH_END: begin
        res_o.vertex_index = cur_base
                           + lodtsig_pkg::IDX_W'(2 * lodtsig_pkg::GRID_SIZE - 1);
        res_o.degenerate   = 1'b1;
        res_o.strip_end    = row_last;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lodtsig_pkg::PH_START;
      row_q   <= '0;
      base_q  <= '0;
      col_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      base_q  <= base_d;
      col_q   <= col_d;
    end
  end

endmodule

@@ src/lodtsig_out.sv @@
// Output result register with valid flag; holds off the input side while a result waits.
// Depends on lodtsig_pkg.

module lodtsig_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  lodtsig_pkg::res_t  res_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output lodtsig_pkg::res_t  res_o
);

  logic              valid_q, valid_d;
  lodtsig_pkg::res_t res_q;

  // A new request is taken when the slot is empty or drains this cycle.
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    if (take_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ src/lod_triangle_strip_index_generator_core.sv @@
// Top level of the LOD triangle strip index generator.
// Depends on lodtsig_pkg, lodtsig_cfg, lodtsig_seq and lodtsig_out.
//
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid/tready/tdata[7:0]       tdata[0] = restart
//  m_axis    out        tvalid/tready/tdata/tuser/tlast vertex_index, degenerate, strip_end
//  cfg       in         cfg_we_i/cfg_idx_i/cfg_wdata_i 0 = level, 1 = step
//
// One index per request, one request per cycle unless the output stalls; a result
// appears the cycle after its take, from the single result register behind the counters.
// Reset clears the counters to row 0 at the row start and sets level 0, step 1.
// While a result is stalled, the next request is held off; when the consumer
// takes the result, a new request is taken in that same cycle.

module lod_triangle_strip_index_generator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [lodtsig_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] restart
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [lodtsig_pkg::TDATA_W-1:0]       m_axis_tdata,  // [20:0] vertex_index
  output logic                                  m_axis_tuser,  // [0] degenerate
  output logic                                  m_axis_tlast,  // strip_end
  input  logic                                  cfg_we_i,
  input  logic [lodtsig_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lodtsig_pkg::CFG_W-1:0]         cfg_wdata_i
);

  logic                             take;
  logic [lodtsig_pkg::STRIDE_W-1:0] stride;
  lodtsig_pkg::res_t                res_next;
  lodtsig_pkg::res_t                res_out;

  assign take = s_axis_tvalid && s_axis_tready;

  lodtsig_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stride_o    (stride)
  );

  lodtsig_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .restart_i (s_axis_tdata[0]),
    .stride_i  (stride),
    .res_o     (res_next)
  );

  lodtsig_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .res_i       (res_next),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .res_o       (res_out)
  );

  assign m_axis_tdata = {(lodtsig_pkg::TDATA_W - lodtsig_pkg::IDX_W)'(0), res_out.vertex_index};
  assign m_axis_tuser = res_out.degenerate;
  assign m_axis_tlast = res_out.strip_end;

endmodule

@@ src/lodtsig_chk.sv @@
// Port-level checker for the LOD triangle strip index generator, with its bind.
// Depends on lodtsig_pkg and lod_triangle_strip_index_generator_core.

module lodtsig_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [lodtsig_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [lodtsig_pkg::TDATA_W-1:0]    m_axis_tdata,
  input logic                               m_axis_tuser,
  input logic                               m_axis_tlast
);

  // The input side only waits on a result that is still pending.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // The final index of a strip is always a degenerate repeat.
  a_end_is_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("strip end not flagged degenerate");

  // A restart request yields index zero, degenerate, in the next cycle.
  a_restart_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=>
      m_axis_tvalid && (m_axis_tdata == '0) && m_axis_tuser && !m_axis_tlast)
    else $error("restart did not produce the strip's first index");

endmodule

bind lod_triangle_strip_index_generator_core lodtsig_chk u_lodtsig_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/tb_lod_triangle_strip_index_generator_core.sv @@
// Testbench for lod_triangle_strip_index_generator_core: directed rows, a short run at the
// coarsest stride, then random restart requests over several detail settings and idle patterns.
// Depends on lodtsig_pkg and the core; results are checked against typed rows or the predictor.
`timescale 1ns / 1ps

module tb_lod_triangle_strip_index_generator_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 60;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_e;

  typedef struct {
    bit                                set_cfg;
    logic [lodtsig_pkg::LEVEL_W-1:0]   lvl;
    logic [lodtsig_pkg::STEP_W-1:0]    step;
    logic                              restart;
    bit                                typed;
    lodtsig_pkg::res_t                 want;
  } strip_row_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [lodtsig_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [lodtsig_pkg::TDATA_W-1:0]      m_axis_tdata;
  logic                                 m_axis_tuser;
  logic                                 m_axis_tlast;
  logic                                 cfg_we_i = 1'b0;
  logic [lodtsig_pkg::CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [lodtsig_pkg::CFG_W-1:0]        cfg_wdata_i = '0;

  lod_triangle_strip_index_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Strip predictor state and its copy of the registers.
  logic [lodtsig_pkg::LEVEL_W-1:0] cfg_level = '0;
  logic [lodtsig_pkg::STEP_W-1:0]  cfg_step  = 8'd1;
  logic [lodtsig_pkg::ROW_W-1:0]   pred_row  = '0;
  logic [lodtsig_pkg::IDX_W-1:0]   pred_base = '0;
  logic [lodtsig_pkg::COL_W-1:0]   pred_col  = '0;
  lodtsig_pkg::phase_e             pred_phase = lodtsig_pkg::PH_START;

  lodtsig_pkg::res_t expected_indices[$];
  strip_row_t        strip_rows[$];
  idle_e             idle_mode = IDLE_NONE;
  bit                hold_request = 1'b0;
  int                mismatch_count = 0;
  int                cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_lod_triangle_strip_index_generator_core: FAIL");
      $finish;
    end
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 60;
      IDLE_BOTH:   return $urandom_range(0, 99) < 15;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 60;
      IDLE_BOTH:     return $urandom_range(0, 99) < 15;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Works out the next strip index for one request and advances the strip state.
  task automatic predict_index(input logic restart, output lodtsig_pkg::res_t want);
    int unsigned lv;
    int unsigned stride;
    int unsigned next_col;
    want = '0;
    if (restart) begin
      pred_row   = '0;
      pred_base  = '0;
      pred_col   = '0;
      pred_phase = lodtsig_pkg::PH_START;
    end
    case (pred_phase)
      lodtsig_pkg::PH_START: begin
        want.vertex_index = pred_base;
        want.degenerate   = 1'b1;
        pred_col          = '0;
        pred_phase        = lodtsig_pkg::PH_TOP;
      end
      lodtsig_pkg::PH_TOP: begin
        want.vertex_index = pred_base + pred_col;
        pred_phase        = lodtsig_pkg::PH_BOTTOM;
      end
      lodtsig_pkg::PH_BOTTOM: begin
        want.vertex_index = lodtsig_pkg::IDX_W'(pred_base + lodtsig_pkg::GRID_SIZE + pred_col);
        if (pred_col >= lodtsig_pkg::LAST_COL) begin
          pred_phase = lodtsig_pkg::PH_END;
        end else begin
          // A level past the top acts as the top level, and a zero stride as one.
          lv = (cfg_level >= lodtsig_pkg::LEVEL_COUNT) ? lodtsig_pkg::LEVEL_COUNT - 1
                                                       : cfg_level;
          stride = (lv == 0) ? 1 : lv * cfg_step;
          if (stride == 0) stride = 1;
          next_col   = pred_col + stride;
          pred_col   = lodtsig_pkg::COL_W'((next_col > lodtsig_pkg::LAST_COL) ?
                                           lodtsig_pkg::LAST_COL : next_col);
          pred_phase = lodtsig_pkg::PH_TOP;
        end
      end
      default: begin
        want.vertex_index = lodtsig_pkg::IDX_W'(pred_base + lodtsig_pkg::GRID_SIZE
                                                + lodtsig_pkg::LAST_COL);
        want.degenerate   = 1'b1;
        if (pred_row >= lodtsig_pkg::GRID_SIZE - 2) begin
          want.strip_end = 1'b1;
          pred_row   = '0;
          pred_base  = '0;
          pred_col   = '0;
          pred_phase = lodtsig_pkg::PH_START;
        end else begin
          pred_row   = pred_row + 1'b1;
          pred_base  = lodtsig_pkg::IDX_W'(pred_base + lodtsig_pkg::GRID_SIZE);
          pred_col   = '0;
          pred_phase = lodtsig_pkg::PH_START;
        end
      end
    endcase
  endtask

  task automatic send_request(input logic restart, output lodtsig_pkg::res_t predicted);
    if (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (sender_idles()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(lodtsig_pkg::IN_TDATA_W-1){1'b0}}, restart};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_index(restart, predicted);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_indices.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // The level write carries random upper bits, which the block must ignore.
  task automatic write_config(input logic [lodtsig_pkg::LEVEL_W-1:0] lvl,
                              input logic [lodtsig_pkg::STEP_W-1:0] step);
    logic [lodtsig_pkg::CFG_W-lodtsig_pkg::LEVEL_W-1:0] junk;
    junk = (lodtsig_pkg::CFG_W - lodtsig_pkg::LEVEL_W)'(
             $urandom_range(0, (1 << (lodtsig_pkg::CFG_W - lodtsig_pkg::LEVEL_W)) - 1));
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= lodtsig_pkg::CFG_LEVEL;
    cfg_wdata_i <= {junk, lvl};
    @(posedge clk_i);
    cfg_idx_i   <= lodtsig_pkg::CFG_STEP;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_level = lvl;
    cfg_step  = step;
  endtask

  task automatic add_row(input bit set_cfg, input int lvl, input int step,
                         input logic restart, input bit typed, input int idx,
                         input logic deg, input logic last);
    strip_row_t r;
    r.set_cfg = set_cfg;
    r.lvl     = lvl[lodtsig_pkg::LEVEL_W-1:0];
    r.step    = step[lodtsig_pkg::STEP_W-1:0];
    r.restart = restart;
    r.typed   = typed;
    r.want    = lodtsig_pkg::res_t'({idx[lodtsig_pkg::IDX_W-1:0], deg, last});
    strip_rows.push_back(r);
  endtask

  task automatic check_result();
    lodtsig_pkg::res_t want;
    if (expected_indices.size() == 0) begin
      report($sformatf("index %0d arrived with nothing expected",
                       m_axis_tdata[lodtsig_pkg::IDX_W-1:0]));
      return;
    end
    want = expected_indices.pop_front();
    if (m_axis_tdata[lodtsig_pkg::IDX_W-1:0] !== want.vertex_index)
      report($sformatf("vertex_index %0d, expected %0d",
                       m_axis_tdata[lodtsig_pkg::IDX_W-1:0], want.vertex_index));
    if (m_axis_tuser !== want.degenerate)
      report($sformatf("degenerate %b, expected %b at index %0d",
                       m_axis_tuser, want.degenerate, want.vertex_index));
    if (m_axis_tlast !== want.strip_end)
      report($sformatf("strip_end %b, expected %b at index %0d",
                       m_axis_tlast, want.strip_end, want.vertex_index));
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !receiver_stalls();
      end
    end
  end

  initial begin : stimulus
    lodtsig_pkg::res_t               want;
    logic [lodtsig_pkg::STEP_W-1:0]  step_val;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset: row start, then columns 0 and 1 at level 0.
    add_row(0, 0, 1, 1'b0, 1,    0, 1'b1, 1'b0);
    add_row(0, 0, 1, 1'b0, 1,    0, 1'b0, 1'b0);
    add_row(0, 0, 1, 1'b0, 1, 1201, 1'b0, 1'b0);
    add_row(0, 0, 1, 1'b0, 1,    1, 1'b0, 1'b0);
    add_row(0, 0, 1, 1'b0, 1, 1202, 1'b0, 1'b0);
    // Restart mid-row emits the first index at once.
    add_row(0, 0, 1, 1'b1, 1,    0, 1'b1, 1'b0);
    add_row(0, 0, 1, 1'b0, 1,    0, 1'b0, 1'b0);
    add_row(0, 0, 1, 1'b0, 1, 1201, 1'b0, 1'b0);
    // Widest stride set mid-strip: it counts on from column 1 and clamps to the last column.
    add_row(1, 7, 255, 1'b0, 1,    1, 1'b0, 1'b0);
    add_row(0, 7, 255, 1'b0, 1, 1202, 1'b0, 1'b0);
    add_row(0, 7, 255, 1'b0, 1, 1200, 1'b0, 1'b0);
    add_row(0, 7, 255, 1'b0, 1, 2401, 1'b0, 1'b0);
    add_row(0, 7, 255, 1'b0, 1, 2401, 1'b1, 1'b0);
    add_row(0, 7, 255, 1'b0, 1, 1201, 1'b1, 1'b0);
    add_row(0, 7, 255, 1'b0, 1, 1201, 1'b0, 1'b0);
    add_row(0, 7, 255, 1'b0, 1, 2402, 1'b0, 1'b0);
    add_row(0, 7, 255, 1'b1, 1,    0, 1'b1, 1'b0);
    // A zero step with a nonzero level acts as stride one.
    add_row(1, 3, 0, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(0, 3, 0, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(0, 3, 0, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(1, 1, 200, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(0, 1, 200, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(0, 1, 200, 1'b0, 0, 0, 1'b0, 1'b0);
    add_row(0, 1, 200, 1'b1, 0, 0, 1'b0, 1'b0);

    idle_mode = IDLE_NONE;
    foreach (strip_rows[i]) begin
      if (strip_rows[i].set_cfg) begin
        drain_results();
        write_config(strip_rows[i].lvl, strip_rows[i].step);
      end
      send_request(strip_rows[i].restart, want);
      expected_indices.push_back(strip_rows[i].typed ? strip_rows[i].want : want);
    end

    // A few row pairs at the coarsest stride: six indices per row pair.
    drain_results();
    write_config(3'd7, 8'd255);
    idle_mode = IDLE_BOTH;
    send_request(1'b1, want);
    expected_indices.push_back(want);
    for (int k = 0; k < 30; k++) begin
      send_request(1'b0, want);
      expected_indices.push_back(want);
    end

    // Random part: each phase picks a level and step and an idle pattern; restarts are
    // rare so the strip gets well into its rows.
    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p % 4)
        0:       step_val = 8'd255;
        1:       step_val = 8'd0;
        2:       step_val = 8'd1;
        default: step_val = lodtsig_pkg::STEP_W'($urandom_range(1, 255));
      endcase
      write_config(p[lodtsig_pkg::LEVEL_W-1:0], step_val);
      idle_mode = idle_e'(p % 4);
      // The receiver holds off for a long stretch so the block backs up into its input.
      if (p == 0 || p == 5) hold_request = 1'b1;
      for (int k = 0; k < 112; k++) begin
        send_request($urandom_range(0, 39) == 0, want);
        expected_indices.push_back(want);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_indices.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_lod_triangle_strip_index_generator_core: PASS");
    end else begin
      $display("tb_lod_triangle_strip_index_generator_core: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lodtsig_pkg.sv
src/lodtsig_cfg.sv
src/lodtsig_seq.sv
src/lodtsig_out.sv
src/lod_triangle_strip_index_generator_core.sv
src/lodtsig_chk.sv
tb/tb_lod_triangle_strip_index_generator_core.sv
